/* hw/rtl/lrufr_pkg.sv */
// Shared types and constants for the LRU frame replacement unit.
package lrufr_pkg;

    localparam int FRAME_W        = 6;
    localparam int FRAME_DEPTH    = 1 << FRAME_W;
    localparam int TDATA_W        = 8;
    localparam int DEFAULT_FRAMES = 64;

    typedef logic [FRAME_W-1:0] frame_t;

    typedef enum logic {
        OP_REFERENCE = 1'b0,
        OP_EVICT     = 1'b1
    } op_t;

endpackage

/* hw/rtl/lrufr_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
module lrufr_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/lru_frame_replacement_unit.sv */
// LRU frame replacement unit: doubly linked recency list kept in two pointer RAMs.
// A reference to an absent frame, or to the most recent one, completes in ST_IDLE;
// a reference to any other listed frame goes on through ST_REF_RD and ST_REF_APPEND
// (pointer read, unlink, append). An evict reads the next pointer, then waits in
// ST_EVICT_RD until the output is free and registers its result there.
// Reset (rst_n low, asynchronous) empties the list at once; the RAMs need no clearing.
module lru_frame_replacement_unit #(
    parameter int FRAMES = lrufr_pkg::DEFAULT_FRAMES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lrufr_pkg::TDATA_W-1:0] s_tdata,  // [5:0] frame_number, [7:6] zero
    input  logic                         s_tuser,   // [0] opcode
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lrufr_pkg::TDATA_W-1:0] m_tdata,  // [5:0] victim_frame, [7:6] zero
    output logic                         m_tuser    // [0] was_empty
);

    import lrufr_pkg::*;

    localparam int CW = $clog2(FRAMES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVICT_RD,
        ST_REF_RD,
        ST_REF_APPEND
    } state_t;

    state_t                  state_reg;
    frame_t                  head_reg;
    frame_t                  tail_reg;
    frame_t                  cur_reg;
    logic [CW-1:0]           count_reg;
    logic [FRAME_DEPTH-1:0]  present_reg;
    logic                    m_tvalid_reg;
    frame_t                  victim_reg;
    logic                    empty_reg;

    logic   in_fire;
    op_t    in_op;
    frame_t in_frame;
    logic   hit;
    logic   full;
    logic   out_free;

    logic   nx_we, nx_re, pv_we, pv_re;
    frame_t nx_waddr, nx_wdata, nx_raddr, nx_rdata;
    frame_t pv_waddr, pv_wdata, pv_raddr, pv_rdata;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign in_op    = op_t'(s_tuser);
    assign in_frame = s_tdata[FRAME_W-1:0];
    assign hit      = present_reg[in_frame];
    assign full     = (count_reg == CW'(FRAMES));
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(TDATA_W-FRAME_W){1'b0}}, victim_reg};
    assign m_tuser  = empty_reg;

    // Pointer RAM control. Reads and writes never share a cycle, so a read
    // always sees every earlier write without forwarding.
    always_comb
    begin
        nx_we    = 1'b0;
        nx_waddr = tail_reg;
        nx_wdata = in_frame;
        nx_re    = 1'b0;
        nx_raddr = in_frame;
        pv_we    = 1'b0;
        pv_waddr = in_frame;
        pv_wdata = tail_reg;
        pv_re    = 1'b0;
        pv_raddr = in_frame;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_op == OP_EVICT)
                    begin
                        nx_re    = 1'b1;
                        nx_raddr = head_reg;
                    end
                    else if (hit)
                    begin
                        nx_re = (in_frame != tail_reg);
                        pv_re = (in_frame != tail_reg);
                    end
                    else if (!full && count_reg != '0)
                    begin
                        nx_we = 1'b1;
                        pv_we = 1'b1;
                    end
                end
            end
            ST_REF_RD:
            begin
                // Unlink: predecessor skips to successor, successor points back.
                nx_we    = (cur_reg != head_reg);
                nx_waddr = pv_rdata;
                nx_wdata = nx_rdata;
                pv_we    = 1'b1;
                pv_waddr = nx_rdata;
                pv_wdata = pv_rdata;
            end
            ST_REF_APPEND:
            begin
                nx_we    = 1'b1;
                nx_waddr = tail_reg;
                nx_wdata = cur_reg;
                pv_we    = 1'b1;
                pv_waddr = cur_reg;
                pv_wdata = tail_reg;
            end
            default:
            begin
            end
        endcase
    end

    lrufr_ram #(
        .WIDTH(FRAME_W),
        .DEPTH(FRAME_DEPTH)
    ) u_next_ram (
        .clk  (clk),
        .we   (nx_we),
        .waddr(nx_waddr),
        .wdata(nx_wdata),
        .re   (nx_re),
        .raddr(nx_raddr),
        .rdata(nx_rdata)
    );

    lrufr_ram #(
        .WIDTH(FRAME_W),
        .DEPTH(FRAME_DEPTH)
    ) u_prev_ram (
        .clk  (clk),
        .we   (pv_we),
        .waddr(pv_waddr),
        .wdata(pv_wdata),
        .re   (pv_re),
        .raddr(pv_raddr),
        .rdata(pv_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            cur_reg      <= '0;
            count_reg    <= '0;
            present_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            victim_reg   <= '0;
            empty_reg    <= 1'b0;
        end
        else
        begin
            // While an evict is finishing, its own branch decides the valid flag.
            if (m_tvalid_reg && m_tready && state_reg != ST_EVICT_RD)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (in_op == OP_EVICT)
                        begin
                            state_reg <= ST_EVICT_RD;
                        end
                        else if (hit)
                        begin
                            // Already the most recent frame: nothing moves.
                            if (in_frame != tail_reg)
                            begin
                                cur_reg   <= in_frame;
                                state_reg <= ST_REF_RD;
                            end
                        end
                        else if (!full)
                        begin
                            present_reg[in_frame] <= 1'b1;
                            count_reg             <= count_reg + 1'b1;
                            tail_reg              <= in_frame;
                            if (count_reg == '0)
                            begin
                                head_reg <= in_frame;
                            end
                        end
                    end
                end
                ST_EVICT_RD:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                        if (count_reg == '0)
                        begin
                            victim_reg <= '0;
                            empty_reg  <= 1'b1;
                        end
                        else
                        begin
                            victim_reg            <= head_reg;
                            empty_reg             <= 1'b0;
                            present_reg[head_reg] <= 1'b0;
                            count_reg             <= count_reg - 1'b1;
                            head_reg              <= nx_rdata;
                        end
                    end
                end
                ST_REF_RD:
                begin
                    if (cur_reg == head_reg)
                    begin
                        head_reg <= nx_rdata;
                    end
                    state_reg <= ST_REF_APPEND;
                end
                ST_REF_APPEND:
                begin
                    tail_reg  <= cur_reg;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_matches_present: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(present_reg) == int'(count_reg))
        else $error("entry count disagrees with presence bits");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= FRAMES)
        else $error("entry count exceeds capacity");

    a_ends_present: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |-> present_reg[head_reg] && present_reg[tail_reg])
        else $error("list head or tail is not a listed frame");

    a_empty_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("empty evict returned a nonzero frame");

    a_single_entry: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CW'(1) && state_reg == ST_IDLE |-> head_reg == tail_reg)
        else $error("single-entry list has distinct head and tail");
`endif

endmodule
